@@ design/dlrp_pkg.sv @@
package dlrp_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES_DEF = 5;

  localparam logic [9:0] LVC_RESET     = 10'd420;
  localparam logic [7:0] TIMEOUT_RESET = 8'd100;

  // Register indexes
  localparam logic [0:0] REG_LVC     = 1'b0;
  localparam logic [0:0] REG_TIMEOUT = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_REPLY  = 3'd0;
  localparam logic [2:0] KIND_ASSIST = 3'd1;
  localparam logic [2:0] KIND_MODE   = 3'd2;
  localparam logic [2:0] KIND_LIGHTS = 3'd3;
  localparam logic [2:0] KIND_LIMIT  = 3'd4;

  // Message types and opcodes
  localparam logic [7:0] TYPE_READ  = 8'h11;
  localparam logic [7:0] TYPE_WRITE = 8'h16;
  localparam logic [7:0] OP_STATUS  = 8'h08;
  localparam logic [7:0] OP_CURRENT = 8'h0a;
  localparam logic [7:0] OP_BATTERY = 8'h11;
  localparam logic [7:0] OP_SPEED   = 8'h20;
  localparam logic [7:0] OP_Z3A     = 8'h21;
  localparam logic [7:0] OP_Z3B     = 8'h22;
  localparam logic [7:0] OP_Z3C     = 8'h24;
  localparam logic [7:0] OP_Z5      = 8'h25;
  localparam logic [7:0] OP_MOVING  = 8'h31;
  localparam logic [7:0] OP_ASSIST  = 8'h0b;
  localparam logic [7:0] OP_MODE    = 8'h0c;
  localparam logic [7:0] OP_LIGHTS  = 8'h1a;
  localparam logic [7:0] OP_LIMIT   = 8'h1f;

  // Mode and lights argument codes
  localparam logic [7:0] MODE_ECO   = 8'h02;
  localparam logic [7:0] MODE_SPORT = 8'h04;
  localparam logic [7:0] LIGHTS_OFF = 8'hf0;
  localparam logic [7:0] LIGHTS_ON  = 8'hf1;

  // Map an assist code to a level; bit 4 set means unknown
  function automatic logic [4:0] assist_level(input logic [7:0] code);
    logic [4:0] r;
    case (code)
      8'h00:   r = 5'd0;
      8'h01:   r = 5'd1;
      8'h0b:   r = 5'd2;
      8'h0c:   r = 5'd3;
      8'h0d:   r = 5'd4;
      8'h02:   r = 5'd5;
      8'h15:   r = 5'd6;
      8'h16:   r = 5'd7;
      8'h17:   r = 5'd8;
      8'h03:   r = 5'd9;
      8'h06:   r = 5'd10;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

endpackage

@@ design/display_link_request_parser.sv @@
// Sequence: a tick is handled in S_IDLE; a byte that ends no request stalls the input through S_DEC and S_DONE.
//   The first result is registered in S_EMIT after S_DEC, or after the S_DIV loop for battery percent
//   (q compare-and-subtract steps in the divider loop, q at most 100).
// Flow: one item at a time; results leave one per cycle without stall, and the input
//   reopens once S_EMIT and then S_DONE close out the list after the last result is taken.
// Reset (rst, synchronous): empties the buffer, clears idle count, restores 420/100 registers.
module display_link_request_parser #(
  parameter int unsigned MAX_MESSAGE_BYTES = dlrp_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  input  logic [11:0] battery_current_x10,
  input  logic [9:0]  battery_voltage_x10,
  input  logic [15:0] wheel_ticks_per_minute,
  input  logic        wheel_moving,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [15:0] value,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int unsigned AW = $clog2(MAX_MESSAGE_BYTES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_DIV  = 5'b00100,
    S_EMIT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [9:0]  lvc;
  logic [7:0]  timeout;
  logic [7:0]  mem [MAX_MESSAGE_BYTES];
  logic [CW-1:0] byte_count;
  logic [7:0]  idle_ms;

  // Latched item
  logic [7:0]  b0, b1, b2, b3, b4;
  logic [11:0] cur;
  logic [9:0]  volt;
  logic [15:0] speed;
  logic        moving;

  // Result list
  logic [2:0]  res_kind;
  logic [15:0] res_v0, res_v1, res_v2;
  logic [2:0]  res_n;
  logic [2:0]  res_i;

  // Divider
  logic [16:0] num;
  logic [9:0]  den;
  logic [6:0]  quo;

  logic [10:0] maxv;
  logic [9:0]  vclamp;
  logic [7:0]  cur2;
  logic [15:0] cur_prod;
  logic [4:0]  lvl_code;

  // Decoded request
  logic        dec_keep;
  logic        dec_div;
  logic [2:0]  dec_kind;
  logic [15:0] dec_v0, dec_v1, dec_v2;
  logic [2:0]  dec_n;

  assign maxv     = 11'(({3'b000, lvc} * 13'd7) >> 2);
  assign vclamp   = ({1'b0, volt} > maxv) ? maxv[9:0] : volt;
  assign cur2     = {cur[6:0], 1'b0};
  // Divide by ten through a reciprocal multiply, exact for 8-bit values
  assign cur_prod = {8'd0, cur2} * 16'd205;
  assign lvl_code = dlrp_pkg::assist_level(b2);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Read the first five buffer entries, indexes wrapped to the buffer depth
  always_comb begin
    b0 = mem[0];
    b1 = mem[1 % MAX_MESSAGE_BYTES];
    b2 = mem[2 % MAX_MESSAGE_BYTES];
    b3 = mem[3 % MAX_MESSAGE_BYTES];
    b4 = mem[4 % MAX_MESSAGE_BYTES];
  end

  // Store bytes into the request buffer
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !func && byte_count < CW'(MAX_MESSAGE_BYTES))
      mem[byte_count[AW-1:0]] <= rx_byte;
  end

  // Decode the buffered request into a result list
  always_comb begin
    dec_keep = 1'b0;
    dec_div  = 1'b0;
    dec_kind = dlrp_pkg::KIND_REPLY;
    dec_v0   = '0;
    dec_v1   = '0;
    dec_v2   = '0;
    dec_n    = '0;
    if (b0 == dlrp_pkg::TYPE_READ || b0 == dlrp_pkg::TYPE_WRITE) begin
      if (byte_count < CW'(2)) begin
        dec_keep = 1'b1;
      end else if (b0 == dlrp_pkg::TYPE_READ) begin
        case (b1)
          dlrp_pkg::OP_STATUS: begin
            dec_n = 3'd1;
          end
          dlrp_pkg::OP_CURRENT: begin
            dec_v0 = {11'd0, cur_prod[15:11]};
            dec_v1 = dec_v0;
            dec_n  = 3'd2;
          end
          dlrp_pkg::OP_BATTERY: begin
            dec_n = 3'd2;
            if (maxv <= {1'b0, lvc}) begin
              dec_v0 = (vclamp >= lvc) ? 16'd100 : 16'd0;
              dec_v1 = dec_v0;
            end else if (vclamp > lvc) begin
              dec_div = 1'b1;
            end
          end
          dlrp_pkg::OP_SPEED: begin
            dec_v0 = {8'd0, speed[15:8]};
            dec_v1 = {8'd0, speed[7:0]};
            dec_v2 = {8'd0, 8'(8'h20 + speed[15:8] + speed[7:0])};
            dec_n  = 3'd3;
          end
          dlrp_pkg::OP_Z3A, dlrp_pkg::OP_Z3B, dlrp_pkg::OP_Z3C: begin
            dec_n = 3'd3;
          end
          dlrp_pkg::OP_Z5: begin
            dec_n = 3'd5;
          end
          dlrp_pkg::OP_MOVING: begin
            dec_v0 = moving ? 16'h30 : 16'h31;
            dec_v1 = dec_v0;
            dec_n  = 3'd2;
          end
          default: ;
        endcase
      end else begin
        case (b1)
          dlrp_pkg::OP_ASSIST: begin
            if (byte_count < CW'(3)) dec_keep = 1'b1;
            else if (!lvl_code[4]) begin
              dec_kind = dlrp_pkg::KIND_ASSIST;
              dec_v0   = {12'd0, lvl_code[3:0]};
              dec_n    = 3'd1;
            end
          end
          dlrp_pkg::OP_MODE: begin
            if (byte_count < CW'(3)) dec_keep = 1'b1;
            else if (b2 == dlrp_pkg::MODE_ECO || b2 == dlrp_pkg::MODE_SPORT) begin
              dec_kind = dlrp_pkg::KIND_MODE;
              dec_v0   = {15'd0, b2 == dlrp_pkg::MODE_SPORT};
              dec_n    = 3'd1;
            end
          end
          dlrp_pkg::OP_LIGHTS: begin
            if (byte_count < CW'(3)) dec_keep = 1'b1;
            else if (b2 == dlrp_pkg::LIGHTS_OFF || b2 == dlrp_pkg::LIGHTS_ON) begin
              dec_kind = dlrp_pkg::KIND_LIGHTS;
              dec_v0   = {15'd0, b2 == dlrp_pkg::LIGHTS_ON};
              dec_n    = 3'd1;
            end
          end
          dlrp_pkg::OP_LIMIT: begin
            if (byte_count < CW'(5)) dec_keep = 1'b1;
            else if (8'(b2 + b3) == b4) begin
              dec_kind = dlrp_pkg::KIND_LIMIT;
              dec_v0   = {b2, b3};
              dec_n    = 3'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      lvc        <= dlrp_pkg::LVC_RESET;
      timeout    <= dlrp_pkg::TIMEOUT_RESET;
      byte_count <= '0;
      idle_ms    <= '0;
      out_valid  <= 1'b0;
      res_n      <= '0;
      res_i      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == dlrp_pkg::REG_LVC) lvc <= cfg_data[9:0];
            else timeout <= cfg_data[7:0];
          end
          if (in_valid) begin
            cur    <= battery_current_x10;
            volt   <= battery_voltage_x10;
            speed  <= wheel_ticks_per_minute;
            moving <= wheel_moving;
            if (func) begin
              if (byte_count != '0) begin
                if (idle_ms >= timeout) begin
                  byte_count <= '0;
                  idle_ms    <= '0;
                end else idle_ms <= idle_ms + 8'd1;
              end
            end else begin
              idle_ms <= '0;
              if (byte_count >= CW'(MAX_MESSAGE_BYTES)) byte_count <= '0;
              else begin
                byte_count <= byte_count + CW'(1);
                state      <= S_DEC;
              end
            end
          end
        end
        // Load the result list, keep or clear the buffer
        S_DEC: begin
          res_kind <= dec_kind;
          res_v0   <= dec_v0;
          res_v1   <= dec_v1;
          res_v2   <= dec_v2;
          res_n    <= dec_n;
          res_i    <= '0;
          quo      <= '0;
          den      <= 10'(maxv - {1'b0, lvc});
          num      <= 17'(({7'd0, vclamp} - {7'd0, lvc}) * 17'd100);
          if (!dec_keep) byte_count <= '0;
          if (dec_div) state <= S_DIV;
          else if (dec_n != '0) state <= S_EMIT;
          else state <= S_DONE;
        end
        // One compare and subtract per cycle
        S_DIV: begin
          if (num >= {7'd0, den} && quo < 7'd100) begin
            num <= num - {7'd0, den};
            quo <= quo + 7'd1;
          end else begin
            res_v0 <= {9'd0, quo};
            res_v1 <= {9'd0, quo};
            res_n  <= 3'd2;
            state  <= S_EMIT;
          end
        end
        // Present results one at a time
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            if (res_i == res_n) begin
              out_valid <= 1'b0;
              state     <= S_DONE;
            end else begin
              out_valid <= 1'b1;
              kind      <= res_kind;
              value     <= (res_i == 3'd0) ? res_v0 : (res_i == 3'd1) ? res_v1 :
                           (res_i == 3'd2 && res_kind == dlrp_pkg::KIND_REPLY) ? res_v2 : '0;
              last      <= (res_i + 3'd1 == res_n);
              res_i     <= res_i + 3'd1;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
